@@ src/cfbs_pkg.sv @@
// Shared types and constants for the cover-fit bilinear scaler.
package cfbs_pkg;

  // Default build sizes
  localparam int unsigned SRC_MAX_WIDTH_DEF  = 256;
  localparam int unsigned SRC_MAX_HEIGHT_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF      = 16;

  // Field widths
  localparam int unsigned COORD_W  = 8;   // load position
  localparam int unsigned CHAN_W   = 8;   // one colour byte
  localparam int unsigned DST_W    = 12;  // target position
  localparam int unsigned SRC_SZ_W = 9;   // source size registers
  localparam int unsigned TGT_W    = 13;  // target size registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TGT_W;
  localparam int unsigned TGT_MAX  = 4096;
  localparam int unsigned PIX_W    = 3 * CHAN_W;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_TGT_WIDTH  = 2'd2,
    CFG_TGT_HEIGHT = 2'd3
  } cfg_idx_e;

  // Scale setup sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_SUM
  } setup_state_e;

endpackage

@@ src/cfbs_if.sv @@
// Valid/ready channel interfaces for request and result items.
interface cfbs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [cfbs_pkg::COORD_W-1:0] src_x;
  logic [cfbs_pkg::COORD_W-1:0] src_y;
  logic [cfbs_pkg::CHAN_W-1:0]  blue_in;
  logic [cfbs_pkg::CHAN_W-1:0]  green_in;
  logic [cfbs_pkg::CHAN_W-1:0]  red_in;
  logic [cfbs_pkg::DST_W-1:0]   dst_x;
  logic [cfbs_pkg::DST_W-1:0]   dst_y;

  modport source (output valid, command, src_x, src_y, blue_in, green_in, red_in,
                  dst_x, dst_y, input ready);
  modport sink   (input valid, command, src_x, src_y, blue_in, green_in, red_in,
                  dst_x, dst_y, output ready);
endinterface

interface cfbs_res_if;
  logic                        valid;
  logic                        ready;
  logic [cfbs_pkg::CHAN_W-1:0] red_out;
  logic [cfbs_pkg::CHAN_W-1:0] green_out;
  logic [cfbs_pkg::CHAN_W-1:0] blue_out;
  logic [cfbs_pkg::DST_W-1:0]  out_x;
  logic [cfbs_pkg::DST_W-1:0]  out_y;

  modport source (output valid, red_out, green_out, blue_out, out_x, out_y, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_x, out_y, output ready);
endinterface

@@ src/cover_fit_bilinear_scaler.sv @@
// Cover-fit bilinear scaler: source pixel store plus six-stage sampling pipeline.
// A sample's result passes through S1 to S6 into the output register; loads give none.
// Throughput: one item per cycle; a full output register stalls the whole pipeline.
// After reset and after every configuration write the scale setup (compare,
// bit-serial divide, multiply, sum) runs with ready low.
// Reset (rst_ni, async, low) restores the size registers; the pixel store is not cleared.
module cover_fit_bilinear_scaler #(
  parameter int unsigned SRC_MAX_WIDTH  = cfbs_pkg::SRC_MAX_WIDTH_DEF,
  parameter int unsigned SRC_MAX_HEIGHT = cfbs_pkg::SRC_MAX_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS      = cfbs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cfbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfbs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cfbs_req_if.sink                        req_i,
  cfbs_res_if.source                      res_o
);
  localparam int unsigned SMAX = (SRC_MAX_WIDTH > SRC_MAX_HEIGHT) ? SRC_MAX_WIDTH
                                                                   : SRC_MAX_HEIGHT;
  localparam int unsigned SZW  = $clog2(SMAX + 1);       // clamped source size
  localparam int unsigned TW   = cfbs_pkg::TGT_W;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned IW   = SZW + F + 1;            // inverse scale / dividend
  localparam int unsigned PW   = IW + TW;                // size * inverse products
  localparam int unsigned NW   = PW + 2;                 // signed coordinate numerator
  localparam int unsigned FW   = SZW + F;                // clamped coordinate
  localparam int unsigned CNTW = $clog2(IW + 1);
  localparam int unsigned XW   = $clog2(SRC_MAX_WIDTH);
  localparam int unsigned YW   = $clog2(SRC_MAX_HEIGHT);
  localparam int unsigned XHW  = (XW > 1) ? XW - 1 : 1;  // column within a bank
  localparam int unsigned YHW  = (YW > 1) ? YW - 1 : 1;  // row within a bank
  localparam int unsigned BAW  = XHW + YHW;
  localparam int unsigned BDEP = 2 ** BAW;
  localparam int unsigned PXW  = cfbs_pkg::PIX_W;
  localparam int unsigned CW   = cfbs_pkg::CHAN_W;
  localparam int unsigned DW   = cfbs_pkg::DST_W;
  localparam int unsigned LW   = cfbs_pkg::COORD_W;
  localparam int unsigned RW   = TW + 1;                 // divider remainder

  // ---------------------------------------------------------------------------
  // Size registers
  // ---------------------------------------------------------------------------
  logic [cfbs_pkg::SRC_SZ_W-1:0] src_w_q, src_h_q;
  logic [TW-1:0]                 tgt_w_q, tgt_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= cfbs_pkg::SRC_SZ_W'(256);
      src_h_q <= cfbs_pkg::SRC_SZ_W'(256);
      tgt_w_q <= TW'(1024);
      tgt_h_q <= TW'(768);
    end else if (cfg_we_i) begin
      case (cfbs_pkg::cfg_idx_e'(cfg_idx_i))
        cfbs_pkg::CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[cfbs_pkg::SRC_SZ_W-1:0];
        cfbs_pkg::CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[cfbs_pkg::SRC_SZ_W-1:0];
        cfbs_pkg::CFG_TGT_WIDTH:  tgt_w_q <= cfg_data_i;
        cfbs_pkg::CFG_TGT_HEIGHT: tgt_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize acts as the maximum
  logic [SZW-1:0] sw_c, sh_c;
  logic [TW-1:0]  tw_c, th_c;

  always_comb begin
    if (src_w_q == '0)                  sw_c = SZW'(1);
    else if (32'(src_w_q) > SRC_MAX_WIDTH) sw_c = SZW'(SRC_MAX_WIDTH);
    else                                sw_c = SZW'(src_w_q);
    if (src_h_q == '0)                  sh_c = SZW'(1);
    else if (32'(src_h_q) > SRC_MAX_HEIGHT) sh_c = SZW'(SRC_MAX_HEIGHT);
    else                                sh_c = SZW'(src_h_q);
    if (tgt_w_q == '0)                  tw_c = TW'(1);
    else if (32'(tgt_w_q) > cfbs_pkg::TGT_MAX) tw_c = TW'(cfbs_pkg::TGT_MAX);
    else                                tw_c = tgt_w_q;
    if (tgt_h_q == '0)                  th_c = TW'(1);
    else if (32'(tgt_h_q) > cfbs_pkg::TGT_MAX) th_c = TW'(cfbs_pkg::TGT_MAX);
    else                                th_c = tgt_h_q;
  end

  // ---------------------------------------------------------------------------
  // Scale setup: pick the smaller ratio, divide one bit per cycle, then form
  // the per-axis offsets so a sample needs one multiply and one add per axis.
  // ---------------------------------------------------------------------------
  cfbs_pkg::setup_state_e st_q, st_d;
  logic [CNTW-1:0]      cnt_q;
  logic [IW-1:0]        quo_q;     // dividend shifting out, quotient shifting in
  logic [RW-1:0]        rem_q;
  logic [TW-1:0]        den_q;
  logic [SZW-1:0]       sw_q, sh_q;
  logic [TW-1:0]        tw_q, th_q;
  logic [PW-1:0]        ptw_q, pth_q;
  logic signed [NW-1:0] cx_q, cy_q;
  logic [IW:0]          kx_q;      // twice the inverse scale
  logic [FW-1:0]        topx_q, topy_q;
  logic [XW-1:0]        swm1_q;
  logic [YW-1:0]        shm1_q;

  logic [SZW+TW-1:0] cross_w, cross_h;
  logic [RW-1:0]     rem_sh;
  logic [IW-1:0]     inv;

  assign cross_w = (SZW+TW)'(sw_c) * (SZW+TW)'(th_c);
  assign cross_h = (SZW+TW)'(sh_c) * (SZW+TW)'(tw_c);
  assign rem_sh  = {rem_q[RW-2:0], quo_q[IW-1]};
  assign inv     = quo_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      cfbs_pkg::ST_IDLE: st_d = cfbs_pkg::ST_IDLE;
      cfbs_pkg::ST_CMP:  st_d = cfbs_pkg::ST_DIV;
      cfbs_pkg::ST_DIV:  if (cnt_q == CNTW'(1)) st_d = cfbs_pkg::ST_MUL;
      cfbs_pkg::ST_MUL:  st_d = cfbs_pkg::ST_SUM;
      cfbs_pkg::ST_SUM:  st_d = cfbs_pkg::ST_IDLE;
      default:           st_d = cfbs_pkg::ST_CMP;
    endcase
    if (cfg_we_i) st_d = cfbs_pkg::ST_CMP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= cfbs_pkg::ST_CMP;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == cfbs_pkg::ST_CMP) cnt_q <= CNTW'(IW);
      else if (st_q == cfbs_pkg::ST_DIV) cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      cfbs_pkg::ST_CMP: begin
        sw_q  <= sw_c;
        sh_q  <= sh_c;
        tw_q  <= tw_c;
        th_q  <= th_c;
        rem_q <= '0;
        if (cross_w <= cross_h) begin
          quo_q <= (IW'(sw_c) << F) + IW'(tw_c >> 1);
          den_q <= tw_c;
        end else begin
          quo_q <= (IW'(sh_c) << F) + IW'(th_c >> 1);
          den_q <= th_c;
        end
      end
      cfbs_pkg::ST_DIV: begin
        if (rem_sh >= RW'(den_q)) begin
          rem_q <= rem_sh - RW'(den_q);
          quo_q <= {quo_q[IW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[IW-2:0], 1'b0};
        end
      end
      cfbs_pkg::ST_MUL: begin
        ptw_q <= PW'(tw_q) * PW'(inv);
        pth_q <= PW'(th_q) * PW'(inv);
      end
      cfbs_pkg::ST_SUM: begin
        // x: (sw-1)<<F + (1-tw)*inv ; y: (sh-1)<<F + (th-1)*inv
        cx_q   <= $signed(NW'(FW'(sw_q - SZW'(1)) << F)) + $signed(NW'(inv))
                  - $signed(NW'(ptw_q));
        cy_q   <= $signed(NW'(FW'(sh_q - SZW'(1)) << F)) + $signed(NW'(pth_q))
                  - $signed(NW'(inv));
        kx_q   <= {inv, 1'b0};
        topx_q <= FW'(sw_q - SZW'(1)) << F;
        topy_q <= FW'(sh_q - SZW'(1)) << F;
        swm1_q <= XW'(sw_q - SZW'(1));
        shm1_q <= YW'(sh_q - SZW'(1));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sampling pipeline, all stages advance together
  // ---------------------------------------------------------------------------
  logic adv, acc;
  logic o_v_q;

  assign adv         = !o_v_q || res_o.ready;
  assign req_i.ready = adv && (st_q == cfbs_pkg::ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;

  // S1: capture, multiply target position by the step
  logic          v1_q, smp1_q, ld1_q;
  logic [DW-1:0] dx1_q, dy1_q;
  logic [PW-1:0] px1_q, py1_q;
  logic [LW-1:0] sx1_q, sy1_q;
  logic [PXW-1:0] pix1_q;

  // S2: numerators
  logic                 v2_q, smp2_q, ld2_q;
  logic [DW-1:0]        dx2_q, dy2_q;
  logic signed [NW-1:0] nx2_q, ny2_q;
  logic [LW-1:0]        sx2_q, sy2_q;
  logic [PXW-1:0]       pix2_q;

  // S3: clamped coordinates, drive the store
  logic           v3_q, smp3_q, ld3_q;
  logic [DW-1:0]  dx3_q, dy3_q;
  logic [FW-1:0]  fx3_q, fy3_q;
  logic [LW-1:0]  sx3_q, sy3_q;
  logic [PXW-1:0] pix3_q;

  // S4: store data out, tap routing
  logic          v4_q, x0p4_q, y0p4_q, xn4_q, yn4_q;
  logic [DW-1:0] dx4_q, dy4_q;
  logic [7:0]    wx4_q, wy4_q;

  // S5: horizontal blend
  logic          v5_q;
  logic [DW-1:0] dx5_q, dy5_q;
  logic [7:0]    wy5_q;
  logic [2*CW:0] top5_q [3];
  logic [2*CW:0] bot5_q [3];

  // S6: output register
  logic [CW-1:0] ch6_q [3];
  logic [DW-1:0] dx6_q, dy6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= acc;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q && smp3_q;   // loads leave the pipeline at the store
      v5_q  <= v4_q;
      o_v_q <= v5_q;
    end
  end

  // S1
  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp1_q <= (req_i.command == cfbs_pkg::CMD_SAMPLE);
      ld1_q  <= (req_i.command == cfbs_pkg::CMD_LOAD) &&
                (32'(req_i.src_x) < SRC_MAX_WIDTH) && (32'(req_i.src_y) < SRC_MAX_HEIGHT);
      dx1_q  <= req_i.dst_x;
      dy1_q  <= req_i.dst_y;
      px1_q  <= PW'(req_i.dst_x) * PW'(kx_q);
      py1_q  <= PW'(req_i.dst_y) * PW'(kx_q);
      sx1_q  <= req_i.src_x;
      sy1_q  <= req_i.src_y;
      pix1_q <= {req_i.red_in, req_i.green_in, req_i.blue_in};
    end
  end

  // S2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp2_q <= smp1_q;
      ld2_q  <= ld1_q;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      nx2_q  <= cx_q + $signed(NW'(px1_q));
      ny2_q  <= cy_q - $signed(NW'(py1_q));
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      pix2_q <= pix1_q;
    end
  end

  // S3: halve with rounding up, clamp to [0, size-1]
  logic [NW-1:0] hx, hy;
  logic [FW-1:0] fx_d, fy_d;

  always_comb begin
    hx = NW'(nx2_q + NW'(1)) >> 1;
    hy = NW'(ny2_q + NW'(1)) >> 1;
    if (nx2_q <= 0)             fx_d = '0;
    else if (hx > NW'(topx_q))  fx_d = topx_q;
    else                        fx_d = FW'(hx);
    if (ny2_q <= 0)             fy_d = '0;
    else if (hy > NW'(topy_q))  fy_d = topy_q;
    else                        fy_d = FW'(hy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp3_q <= smp2_q;
      ld3_q  <= ld2_q;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      fx3_q  <= fx_d;
      fy3_q  <= fy_d;
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
      pix3_q <= pix2_q;
    end
  end

  // Store: four banks by row and column parity, so the 2x2 taps never collide
  logic [XW-1:0]  x0;
  logic [YW-1:0]  y0;
  logic [XW:0]    x0p1;
  logic [YW:0]    y0p1;
  logic           xn, yn;
  logic [BAW-1:0] raddr [4];
  logic [BAW-1:0] waddr;
  logic [1:0]     wbank;
  logic           wen;
  logic [PXW-1:0] rdata [4];

  always_comb begin
    x0    = fx3_q[F +: XW];
    y0    = fy3_q[F +: YW];
    x0p1  = (XW+1)'(x0) + (XW+1)'(1);
    y0p1  = (YW+1)'(y0) + (YW+1)'(1);
    xn    = (x0 != swm1_q);
    yn    = (y0 != shm1_q);
    for (int b = 0; b < 4; b++) begin
      logic [YHW-1:0] r;
      logic [XHW-1:0] c;
      r = ((b >> 1) == int'(y0[0])) ? YHW'(y0 >> 1) : YHW'(y0p1 >> 1);
      c = ((b & 1) == int'(x0[0])) ? XHW'(x0 >> 1) : XHW'(x0p1 >> 1);
      raddr[b] = {r, c};
    end
    wbank = {sy3_q[0], sx3_q[0]};
    waddr = {YHW'(sy3_q >> 1), XHW'(sx3_q >> 1)};
    wen   = adv && v3_q && ld3_q;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    cfbs_ram #(
      .WIDTH (PXW),
      .DEPTH (BDEP)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (wen && (wbank == 2'(b))),
      .waddr_i (waddr),
      .wdata_i (pix3_q),
      .re_i    (adv),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  // S4
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
      x0p4_q <= x0[0];
      y0p4_q <= y0[0];
      xn4_q  <= xn;
      yn4_q  <= yn;
      wx4_q  <= fx3_q[F-1 -: 8];
      wy4_q  <= fy3_q[F-1 -: 8];
    end
  end

  // S5: route taps, horizontal weights
  logic [PXW-1:0] p00, p01, p10, p11;
  logic [8:0]     iwx, iwy;
  logic           bx1, by1;

  always_comb begin
    bx1 = xn4_q ? !x0p4_q : x0p4_q;
    by1 = yn4_q ? !y0p4_q : y0p4_q;
    p00 = rdata[{y0p4_q, x0p4_q}];
    p01 = rdata[{y0p4_q, bx1}];
    p10 = rdata[{by1, x0p4_q}];
    p11 = rdata[{by1, bx1}];
    iwx = 9'd256 - 9'(wx4_q);
    iwy = 9'd256 - 9'(wy5_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx5_q <= dx4_q;
      dy5_q <= dy4_q;
      wy5_q <= wy4_q;
      for (int c = 0; c < 3; c++) begin
        // channel 0 is red (top byte)
        top5_q[c] <= (2*CW+1)'(p00[(2-c)*CW +: CW]) * (2*CW+1)'(iwx)
                   + (2*CW+1)'(p01[(2-c)*CW +: CW]) * (2*CW+1)'(wx4_q);
        bot5_q[c] <= (2*CW+1)'(p10[(2-c)*CW +: CW]) * (2*CW+1)'(iwx)
                   + (2*CW+1)'(p11[(2-c)*CW +: CW]) * (2*CW+1)'(wx4_q);
      end
    end
  end

  // S6: vertical blend, round to nearest
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx6_q <= dx5_q;
      dy6_q <= dy5_q;
      for (int c = 0; c < 3; c++) begin
        logic [26:0] s;
        s = 27'(top5_q[c]) * 27'(iwy) + 27'(bot5_q[c]) * 27'(wy5_q) + 27'd32768;
        ch6_q[c] <= s[23:16];
      end
    end
  end

  assign res_o.valid     = o_v_q;
  assign res_o.red_out   = ch6_q[0];
  assign res_o.green_out = ch6_q[1];
  assign res_o.blue_out  = ch6_q[2];
  assign res_o.out_x     = dx6_q;
  assign res_o.out_y     = dy6_q;

endmodule

@@ src/cfbs_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-first).
module cfbs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
